@@ design/wbsh_pkg.sv @@
// ----------------------------------------------------------------------------
// wbsh_pkg
// Shared constants, types and helpers for the windowed byte similarity hash.
// ----------------------------------------------------------------------------
package wbsh_pkg;

  // window of previous bytes and position counter
  localparam int HISTORY_SPAN   = 32;
  localparam int COUNT_BITS     = 32;
  localparam int HIST_DEPTH     = HISTORY_SPAN - 1;
  localparam int WIN_MAX        = HIST_DEPTH * 255;
  localparam int WIN_BITS       = $clog2(WIN_MAX + 1);
  localparam int BYTE_BITS      = 8;

  // per-byte weight is position + 1 + window, product is byte times weight
  localparam int WEIGHT_BITS    = COUNT_BITS + 2;
  localparam int PROD_BITS      = WEIGHT_BITS + BYTE_BITS;
  localparam int ACC_BITS       = 64;
  localparam int ACC_HALF       = ACC_BITS / 2;
  localparam int HALF_BITS      = COUNT_BITS - 1;
  localparam int OUT_COUNT_BITS = 32;

  // queue between front and back
  localparam int Q_DEPTH        = 4;
  localparam int Q_PTR_BITS     = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS     = $clog2(Q_DEPTH + 1);

  // stream widths
  localparam int S_DATA_BITS    = 8;
  localparam int M_DATA_BITS    = ACC_BITS + OUT_COUNT_BITS;

  // what a queued item asks of the back end
  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_END      = 2'd1,
    KIND_BYTE_END = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [BYTE_BITS-1:0]  data_byte;
  } item_t;

  // finished message handed to the final multiply
  typedef struct packed {
    logic                  valid;
    logic [ACC_BITS-1:0]   acc;
    logic [COUNT_BITS-1:0] count;
    logic                  ovf;
  } fin_t;

  function automatic logic kind_has_byte(kind_t k);
    return (k == KIND_BYTE) || (k == KIND_BYTE_END);
  endfunction

  function automatic logic kind_is_last(kind_t k);
    return (k == KIND_END) || (k == KIND_BYTE_END);
  endfunction

  // byte count on the output saturates at its field width
  function automatic logic [OUT_COUNT_BITS-1:0] sat_count(logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS-1:0] upper;
    upper = c >> OUT_COUNT_BITS;
    if (upper != '0) begin
      return '1;
    end
    return OUT_COUNT_BITS'(c);
  endfunction

endpackage

@@ design/wbsh_front.sv @@
// ----------------------------------------------------------------------------
// wbsh_front
// Accepts stream items, drops items that carry neither byte nor end, and
// queues the rest for the back end.
// ----------------------------------------------------------------------------
module wbsh_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [wbsh_pkg::S_DATA_BITS-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          s_tlast,
  input  logic                          advance,
  output logic                          pop,
  output wbsh_pkg::item_t               head
);
  import wbsh_pkg::*;

  item_t                 slots [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_CNT_BITS-1:0] count;
  logic                  keep;
  logic                  push;
  item_t                 incoming;

  // classify the incoming item
  always_comb begin
    keep               = s_tuser | s_tlast;
    incoming.data_byte = s_tdata[BYTE_BITS-1:0];
    if (s_tuser && s_tlast) begin
      incoming.kind = KIND_BYTE_END;
    end else if (s_tuser) begin
      incoming.kind = KIND_BYTE;
    end else begin
      incoming.kind = KIND_END;
    end
  end

  assign s_tready = (count != Q_CNT_BITS'(Q_DEPTH));
  assign push     = s_tvalid & s_tready & keep;
  assign pop      = advance & (count != '0);
  assign head     = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_BITS'(1);
      end
      count <= count + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_BITS'(Q_DEPTH))
    else $error("queue fill level past depth");

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + Q_CNT_BITS'(1)))
    else $error("queue fill level lost an item");

endmodule

@@ design/wbsh_update.sv @@
// ----------------------------------------------------------------------------
// wbsh_update
// Per-byte hash update: window, history and position in the first stage,
// accumulator in the second; closes a message on its end item.
// ----------------------------------------------------------------------------
module wbsh_update (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            pop,
  input  wbsh_pkg::item_t head,
  output wbsh_pkg::fin_t  fin
);
  import wbsh_pkg::*;

  // message state
  logic [BYTE_BITS-1:0]   history [HIST_DEPTH];
  logic [WIN_BITS-1:0]    window_total;
  logic [COUNT_BITS-1:0]  position;
  logic                   overflow_seen;
  logic [ACC_BITS-1:0]    accumulator;

  // first stage result
  logic                   s1_valid;
  logic                   s1_has;
  logic                   s1_last;
  logic [PROD_BITS-1:0]   s1_prod;
  logic [COUNT_BITS-1:0]  s1_count;
  logic                   s1_ovf;

  logic                   has;
  logic                   last;
  logic [WEIGHT_BITS-1:0] weight;
  logic [PROD_BITS-1:0]   prod;
  logic [WIN_BITS-1:0]    window_next;
  logic [COUNT_BITS-1:0]  position_next;
  logic                   overflow_next;
  logic                   pos_full;
  logic [ACC_BITS-1:0]    acc_sum;

  // weight and product from the state before this byte
  always_comb begin
    has           = kind_has_byte(head.kind);
    last          = kind_is_last(head.kind);
    pos_full      = (position == '1);
    weight        = WEIGHT_BITS'(position) + WEIGHT_BITS'(1) + WEIGHT_BITS'(window_total);
    prod          = PROD_BITS'(head.data_byte) * PROD_BITS'(weight);
    window_next   = window_total;
    position_next = position;
    overflow_next = overflow_seen;
    if (has) begin
      window_next   = window_total - WIN_BITS'(history[HIST_DEPTH-1])
                      + WIN_BITS'(head.data_byte);
      position_next = pos_full ? position : position + COUNT_BITS'(1);
      overflow_next = overflow_seen | pos_full;
    end
  end

  // history shift line, cleared at the end of each message
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
        history[k] <= '0;
      end
    end else if (pop) begin
      if (last) begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
          history[k] <= '0;
        end
      end else if (has) begin
        history[0] <= head.data_byte;
        for (int k = 1; k < HIST_DEPTH; k++) begin
          history[k] <= history[k-1];
        end
      end
    end
  end

  // window, position and overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      window_total  <= '0;
      position      <= '0;
      overflow_seen <= 1'b0;
    end else if (pop) begin
      if (last) begin
        window_total  <= '0;
        position      <= '0;
        overflow_seen <= 1'b0;
      end else begin
        window_total  <= window_next;
        position      <= position_next;
        overflow_seen <= overflow_next;
      end
    end
  end

  // first stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_has   <= has;
      s1_last  <= last;
      s1_prod  <= prod;
      s1_count <= position_next;
      s1_ovf   <= overflow_next;
    end
  end

  // accumulator stage
  assign acc_sum = accumulator + (s1_has ? ACC_BITS'(s1_prod) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      fin.valid   <= 1'b0;
    end else if (advance) begin
      fin.valid <= s1_valid & s1_last;
      if (s1_valid) begin
        accumulator <= s1_last ? '0 : acc_sum;
      end
      if (s1_valid && s1_last) begin
        fin.acc   <= acc_sum;
        fin.count <= s1_count;
        fin.ovf   <= s1_ovf;
      end
    end
  end

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    window_total <= WIN_BITS'(WIN_MAX))
    else $error("window sum out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && last) |=> (position == '0 && window_total == '0 && !overflow_seen))
    else $error("message state not cleared after end item");

endmodule

@@ design/wbsh_final.sv @@
// ----------------------------------------------------------------------------
// wbsh_final
// Multiplies the finished accumulator by half the length in two 32-bit
// halves, sums the partial products and holds the result for the sink.
// ----------------------------------------------------------------------------
module wbsh_final (
  input  logic                              clk,
  input  logic                              rst,
  input  wbsh_pkg::fin_t                    fin,
  output logic                              advance,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [wbsh_pkg::M_DATA_BITS-1:0]  m_tdata,
  output logic                              m_tuser
);
  import wbsh_pkg::*;

  logic                      mul_valid;
  logic [ACC_BITS-1:0]       lo_prod;
  logic [ACC_HALF-1:0]       hi_prod;
  logic [OUT_COUNT_BITS-1:0] mul_count;
  logic                      mul_ovf;
  logic [HALF_BITS-1:0]      half_len;
  logic [ACC_BITS-1:0]       hash_value;
  logic [OUT_COUNT_BITS-1:0] byte_count;
  logic                      length_overflow;

  // the back end moves whenever the output register is free or being taken
  assign advance  = !m_tvalid | m_tready;
  assign half_len = fin.count[COUNT_BITS-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else if (advance) begin
      mul_valid <= fin.valid;
      m_tvalid  <= mul_valid;
    end
  end

  // partial products, upper half only needed mod 2^32
  always_ff @(posedge clk) begin
    if (advance && fin.valid) begin
      lo_prod   <= ACC_BITS'(fin.acc[ACC_HALF-1:0]) * ACC_BITS'(half_len);
      hi_prod   <= ACC_HALF'(fin.acc[ACC_BITS-1:ACC_HALF] * ACC_HALF'(half_len));
      mul_count <= sat_count(fin.count);
      mul_ovf   <= fin.ovf;
    end
  end

  // combine partial products into the output register
  always_ff @(posedge clk) begin
    if (advance && mul_valid) begin
      hash_value      <= lo_prod + {hi_prod, {ACC_HALF{1'b0}}};
      byte_count      <= mul_count;
      length_overflow <= mul_ovf;
    end
  end

  assign m_tdata = {byte_count, hash_value};
  assign m_tuser = length_overflow;

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && byte_count < OUT_COUNT_BITS'(2) && !length_overflow)
      |-> (hash_value == '0))
    else $error("short message gave a nonzero hash");

endmodule

@@ design/windowed_byte_similarity_hash_core.sv @@
// ----------------------------------------------------------------------------
// windowed_byte_similarity_hash_core
// Hashes a byte stream with a position and window weighted accumulator and
// emits accumulator times half the length at the end of each message.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+----------------------------------------------------------
//  s_*     | in  | tdata: data_byte[7:0]; tuser: has_byte; tlast: last
//  m_*     | out | tdata: hash_value[63:0], byte_count[95:64];
//          |     | tuser: length_overflow
//
//  one item per cycle sustained while the output is not stalled; the back end
//  takes one byte per cycle through one 8x34 multiply and one 64-bit add per byte
//  a result passes from its end item through the queue, two update stages and
//  the split final multiply into the output register
//  rst clears the queue, message state and valid flags; no clearing pass
//  a stalled output freezes the back end; the four-item queue keeps
//  accepting until full
// ----------------------------------------------------------------------------
module windowed_byte_similarity_hash_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wbsh_pkg::S_DATA_BITS-1:0]  s_tdata,   // data_byte[7:0]
  input  logic                              s_tuser,   // has_byte
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [wbsh_pkg::M_DATA_BITS-1:0]  m_tdata,   // hash_value[63:0], byte_count[95:64]
  output logic                              m_tuser    // length_overflow
);
  import wbsh_pkg::*;

  logic  advance;
  logic  pop;
  item_t head;
  fin_t  fin;

  // front: accept, classify, queue
  wbsh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .advance  (advance),
    .pop      (pop),
    .head     (head)
  );

  // back: per-byte update
  wbsh_update u_update (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .pop     (pop),
    .head    (head),
    .fin     (fin)
  );

  // back: final multiply and output register
  wbsh_final u_final (
    .clk      (clk),
    .rst      (rst),
    .fin      (fin),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ test/wbsh_hash_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbsh_hash_checker
// Watches both stream channels of the hash core, keeps its own model of the
// message state, and compares every emitted hash item with the oldest one
// predicted. Mismatches and unexpected items are counted for the top.
// ----------------------------------------------------------------------------
module wbsh_hash_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [wbsh_pkg::S_DATA_BITS-1:0]  s_tdata,   // data_byte[7:0]
  input  logic                              s_tuser,   // has_byte
  input  logic                              s_tlast,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [wbsh_pkg::M_DATA_BITS-1:0]  m_tdata,   // hash_value[63:0], byte_count[95:64]
  input  logic                              m_tuser,   // length_overflow
  output int                                error_count,
  output int                                outstanding
);
  import wbsh_pkg::*;

  typedef struct packed {
    logic [ACC_BITS-1:0]       hash_value;
    logic [OUT_COUNT_BITS-1:0] byte_count;
    logic                      length_overflow;
  } hash_result_t;

  // model of the message state
  logic [BYTE_BITS-1:0]  history [HIST_DEPTH];
  logic [31:0]           window_sum;
  logic [COUNT_BITS-1:0] msg_position;
  logic [ACC_BITS-1:0]   hash_acc;
  logic                  saw_overflow;

  hash_result_t pending_hashes [$];
  int           fail_total = 0;
  int           queued_total = 0;

  assign error_count = fail_total;
  assign outstanding = queued_total;

  task automatic clear_message();
    for (int k = 0; k < HIST_DEPTH; k++) history[k] = '0;
    window_sum   = '0;
    msg_position = '0;
    hash_acc     = '0;
    saw_overflow = 1'b0;
  endtask

  // fold one accepted input item into the model, queue a hash on last
  task automatic absorb_item(input logic [BYTE_BITS-1:0] b, input logic has,
                             input logic lst);
    logic [63:0]  weight;
    logic [63:0]  wide_pos;
    hash_result_t res;
    if (has) begin
      weight   = 64'(msg_position) + 64'd1;
      hash_acc = hash_acc + 64'(b) * weight + 64'(window_sum) * 64'(b);
      window_sum = window_sum - 32'(history[HIST_DEPTH-1]) + 32'(b);
      for (int k = HIST_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = b;
      // position saturates, overflow sticks
      if (msg_position != '1) begin
        msg_position = msg_position + COUNT_BITS'(1);
      end else begin
        saw_overflow = 1'b1;
      end
    end
    if (lst) begin
      wide_pos            = 64'(msg_position);
      res.hash_value      = hash_acc * (wide_pos >> 1);
      res.byte_count      = (wide_pos > 64'hFFFF_FFFF) ? '1 : wide_pos[31:0];
      res.length_overflow = saw_overflow;
      pending_hashes.push_back(res);
      clear_message();
    end
  endtask

  initial clear_message();

  // compare outgoing items first, then take the incoming one
  always @(posedge clk) begin
    hash_result_t want;
    hash_result_t got;
    if (rst) begin
      clear_message();
      pending_hashes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.hash_value      = m_tdata[ACC_BITS-1:0];
        got.byte_count      = m_tdata[ACC_BITS +: OUT_COUNT_BITS];
        got.length_overflow = m_tuser;
        if (pending_hashes.size() == 0) begin
          $error("unexpected hash item: hash_value %h byte_count %0d", got.hash_value,
                 got.byte_count);
          fail_total++;
        end else begin
          want = pending_hashes.pop_front();
          if (got.hash_value !== want.hash_value) begin
            $error("hash_value mismatch: expected %h actual %h", want.hash_value,
                   got.hash_value);
            fail_total++;
          end
          if (got.byte_count !== want.byte_count) begin
            $error("byte_count mismatch: expected %0d actual %0d", want.byte_count,
                   got.byte_count);
            fail_total++;
          end
          if (got.length_overflow !== want.length_overflow) begin
            $error("length_overflow mismatch: expected %b actual %b",
                   want.length_overflow, got.length_overflow);
            fail_total++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        absorb_item(s_tdata, s_tuser, s_tlast);
      end
    end
    queued_total = pending_hashes.size();
  end

endmodule

@@ test/tb_windowed_byte_similarity_hash_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_byte_similarity_hash_core
// Drives byte messages into the hash core with random gaps and output
// stalls: a directed set of edge messages, then random messages of mixed
// length and content. A side checker predicts and compares every hash.
// ----------------------------------------------------------------------------
module tb_windowed_byte_similarity_hash_core;
  import wbsh_pkg::*;

  localparam int TARGET_ITEMS  = 1330;
  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 20;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_DATA_BITS-1:0] s_tdata  = '0;   // data_byte[7:0]
  logic                   s_tuser  = 1'b0; // has_byte
  logic                   s_tlast  = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_DATA_BITS-1:0] m_tdata;         // hash_value[63:0], byte_count[95:64]
  logic                   m_tuser;         // length_overflow

  int error_count;
  int outstanding;
  int items_sent  = 0;
  int quiet_count = 0;
  bit burst_on    = 1'b0;

  windowed_byte_similarity_hash_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  wbsh_hash_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // output back-pressure, none during the burst stretch
  always @(negedge clk) begin
    m_tready <= burst_on ? 1'b1 : ($urandom_range(99) >= 37);
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
      if (quiet_count >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // present one item at a falling edge and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic has, input logic lst);
    while (!burst_on && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= has;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // hold off input until every predicted hash has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // random message: length shape, content mode, noise and end style
  task automatic send_random_message();
    int   shape;
    int   len;
    int   mode;
    bit   bare_end;
    logic [7:0] b;
    shape = $urandom_range(99);
    if (shape < 6) len = 0;
    else if (shape < 16) len = $urandom_range(90, 32);
    else len = $urandom_range(34, 1);
    mode     = $urandom_range(3);
    bare_end = (len == 0) || ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      // an ignored item with no byte now and then
      if ($urandom_range(99) < 6) send_item(8'($urandom), 1'b0, 1'b0);
      case (mode)
        0: b = 8'($urandom);
        1: b = 8'hFF;
        2: b = 8'h00;
        default: b = $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
      send_item(b, 1'b1, !bare_end && (i == len - 1));
    end
    if (bare_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    bit drained_once;
    drained_once = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty message: bare end only
    send_item(8'hA5, 1'b0, 1'b1);
    // one byte with last, both extremes
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    // two full bytes
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    // ignored no-byte items inside a message, closed by a bare end
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // back to back empty messages
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    // walking bits, closed by 7F with last
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);
    send_item(8'h04, 1'b1, 1'b0);
    send_item(8'h08, 1'b1, 1'b0);
    send_item(8'h10, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b0);
    send_item(8'h40, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);
    wait_drained();

    // random messages, with one stretch of no idling on either side
    while (items_sent < TARGET_ITEMS) begin
      burst_on = (items_sent >= 500) && (items_sent < 700);
      if (!drained_once && items_sent >= 900) begin
        drained_once = 1'b1;
        wait_drained();
      end
      send_random_message();
    end
    burst_on = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
